// ===== hdl/sfm_pkg.sv =====
package sfm_pkg;

	localparam int X_W       = 16;
	localparam int P_W       = 17;
	localparam int CNT_W     = 7;
	localparam int IDX_W     = 6;
	localparam int STORE_DEPTH = 64;
	localparam int SUM_W     = 23;
	localparam int EXP_LIMIT = 3072;
	localparam int ROM_DEPTH = EXP_LIMIT + 1;
	localparam int ROM_AW    = 12;
	localparam int Q62_W     = 63;
	localparam int BASE_W    = 62;
	localparam int STEP_W    = 6;
	localparam int TERMS     = 11;
	localparam int TERM_N_W  = 4;
	localparam int DIVS_W    = 23;
	localparam int PROB_STEPS = 33;

	typedef enum logic [3:0] {
		S_INIT_DIV,
		S_INIT_DWAIT,
		S_INIT_ROM,
		S_INIT_MWAIT,
		S_COLLECT,
		S_EXP_RD,
		S_EXP_ROM,
		S_EXP_ACC,
		S_DIV_RD,
		S_DIV_GO,
		S_DIV_RUN,
		S_DIV_OUT
	} state_t;

	typedef struct packed {
		logic div_start;
		logic div_init;
		logic init_upd;
		logic rom_wr;
		logic rom_step;
		logic in_take;
		logic exp_rd;
		logic exp_rom;
		logic exp_acc;
		logic div_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic n_last;
		logic k_last;
		logic i_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/sfm_div.sv =====
module sfm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sfm_pkg::Q62_W-1:0]    dividend,
	input  logic [sfm_pkg::DIVS_W-1:0]   divisor,
	input  logic [sfm_pkg::STEP_W-1:0]   steps,
	output logic                         busy,
	output logic [sfm_pkg::Q62_W-1:0]    quotient
);

	logic [sfm_pkg::Q62_W-1:0]  quo_q;
	logic [sfm_pkg::DIVS_W-1:0] rem_q;
	logic [sfm_pkg::DIVS_W-1:0] dvs_q;
	logic [sfm_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic [sfm_pkg::DIVS_W:0]   shifted;
	logic [sfm_pkg::DIVS_W+1:0] trial;

	assign shifted = {rem_q, quo_q[sfm_pkg::Q62_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == sfm_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[sfm_pkg::DIVS_W+1]) begin
				rem_q <= trial[sfm_pkg::DIVS_W-1:0];
				quo_q <= {quo_q[sfm_pkg::Q62_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[sfm_pkg::DIVS_W-1:0];
				quo_q <= {quo_q[sfm_pkg::Q62_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/sfm_mul.sv =====
module sfm_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfm_pkg::Q62_W-1:0]   a,
	input  logic [sfm_pkg::BASE_W-1:0]  b,
	output logic                        busy,
	output logic [sfm_pkg::Q62_W-1:0]   product
);

	logic [sfm_pkg::Q62_W-1:0]  a_q;
	logic [sfm_pkg::BASE_W-1:0] b_q;
	logic [sfm_pkg::Q62_W-1:0]  hi_q;
	logic [sfm_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic [sfm_pkg::Q62_W:0]    sum;

	// lsb-first shift and add, dropped bits never carry upward
	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= sfm_pkg::STEP_W'(sfm_pkg::BASE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == sfm_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[sfm_pkg::Q62_W:1];
			b_q  <= {1'b0, b_q[sfm_pkg::BASE_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = hi_q;

endmodule

// ===== hdl/sfm_ctrl.sv =====
module sfm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  sfm_pkg::sts_t sts,
	output sfm_pkg::cmd_t cmd
);

	sfm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfm_pkg::S_INIT_DIV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfm_pkg::S_INIT_DIV: state_d = sfm_pkg::S_INIT_DWAIT;
			sfm_pkg::S_INIT_DWAIT: begin
				if (!sts.div_busy) begin
					state_d = sts.n_last ? sfm_pkg::S_INIT_ROM : sfm_pkg::S_INIT_DIV;
				end
			end
			sfm_pkg::S_INIT_ROM: begin
				state_d = sts.k_last ? sfm_pkg::S_COLLECT : sfm_pkg::S_INIT_MWAIT;
			end
			sfm_pkg::S_INIT_MWAIT: begin
				if (!sts.mul_busy) begin
					state_d = sfm_pkg::S_INIT_ROM;
				end
			end
			sfm_pkg::S_COLLECT: begin
				if (in_valid && in_last) begin
					state_d = sfm_pkg::S_EXP_RD;
				end
			end
			sfm_pkg::S_EXP_RD:  state_d = sfm_pkg::S_EXP_ROM;
			sfm_pkg::S_EXP_ROM: state_d = sfm_pkg::S_EXP_ACC;
			sfm_pkg::S_EXP_ACC: begin
				state_d = sts.i_last ? sfm_pkg::S_DIV_RD : sfm_pkg::S_EXP_RD;
			end
			sfm_pkg::S_DIV_RD: state_d = sfm_pkg::S_DIV_GO;
			sfm_pkg::S_DIV_GO: state_d = sfm_pkg::S_DIV_RUN;
			sfm_pkg::S_DIV_RUN: begin
				if (!sts.div_busy) begin
					state_d = sfm_pkg::S_DIV_OUT;
				end
			end
			sfm_pkg::S_DIV_OUT: begin
				if (sts.out_free) begin
					state_d = sts.i_last ? sfm_pkg::S_COLLECT : sfm_pkg::S_DIV_RD;
				end
			end
			default: state_d = sfm_pkg::S_INIT_DIV;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sfm_pkg::S_INIT_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_init  = 1'b1;
			end
			sfm_pkg::S_INIT_DWAIT: cmd.init_upd = !sts.div_busy;
			sfm_pkg::S_INIT_ROM:   cmd.rom_wr   = 1'b1;
			sfm_pkg::S_INIT_MWAIT: cmd.rom_step = !sts.mul_busy;
			sfm_pkg::S_COLLECT: begin
				in_ready    = 1'b1;
				cmd.in_take = in_valid;
			end
			sfm_pkg::S_EXP_RD:  cmd.exp_rd  = 1'b1;
			sfm_pkg::S_EXP_ROM: cmd.exp_rom = 1'b1;
			sfm_pkg::S_EXP_ACC: cmd.exp_acc = 1'b1;
			sfm_pkg::S_DIV_RD:  cmd.div_rd  = 1'b1;
			sfm_pkg::S_DIV_GO:  cmd.div_start = 1'b1;
			sfm_pkg::S_DIV_RUN: cmd = '0;
			sfm_pkg::S_DIV_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/sfm_dp.sv =====
module sfm_dp #(
	parameter int ROW_MAX = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sfm_pkg::cmd_t             cmd,
	output sfm_pkg::sts_t             sts,
	input  logic [sfm_pkg::X_W-1:0]   x_value,
	output logic                      m_valid,
	input  logic                      m_ready,
	output logic [sfm_pkg::P_W-1:0]   probability,
	output logic                      last_of_row,
	output logic                      row_truncated
);

	localparam logic [sfm_pkg::Q62_W-1:0] ONE_Q62 = sfm_pkg::Q62_W'(1) << 62;
	localparam logic [sfm_pkg::Q62_W-1:0] HALF_LSB = sfm_pkg::Q62_W'(1) << 45;

	logic [sfm_pkg::X_W-1:0] row_mem [0:sfm_pkg::STORE_DEPTH-1];
	logic [sfm_pkg::P_W-1:0] exp_mem [0:sfm_pkg::STORE_DEPTH-1];
	logic [sfm_pkg::P_W-1:0] rom_mem [0:sfm_pkg::ROM_DEPTH-1];

	logic [sfm_pkg::Q62_W-1:0]    term_q, base_q, acc_q;
	logic [sfm_pkg::TERM_N_W-1:0] n_q;
	logic [sfm_pkg::ROM_AW-1:0]   k_q;
	logic signed [sfm_pkg::X_W-1:0] max_q;
	logic [sfm_pkg::CNT_W-1:0]    count_q;
	logic [sfm_pkg::SUM_W-1:0]    sum_q;
	logic                         ovf_q;
	logic [sfm_pkg::IDX_W-1:0]    i_q;
	logic [sfm_pkg::X_W-1:0]      row_rd_q;
	logic [sfm_pkg::P_W-1:0]      rom_rd_q;
	logic [sfm_pkg::P_W-1:0]      exp_rd_q;
	logic                         zero_q;
	logic                         m_valid_q;
	logic [sfm_pkg::P_W-1:0]      prob_q;
	logic                         last_q;
	logic                         trunc_q;

	logic                         div_busy, mul_busy;
	logic [sfm_pkg::Q62_W-1:0]    quo, prod;
	logic [sfm_pkg::Q62_W-1:0]    div_dividend;
	logic [sfm_pkg::DIVS_W-1:0]   div_divisor;
	logic [sfm_pkg::STEP_W-1:0]   div_steps;
	logic [sfm_pkg::Q62_W-1:0]    rounded;
	logic signed [sfm_pkg::X_W:0] diff;
	logic                         room;
	logic                         i_last;
	logic [sfm_pkg::P_W-1:0]      e_val;

	assign rounded = acc_q + HALF_LSB;
	assign diff    = {max_q[sfm_pkg::X_W-1], max_q}
		- $signed({row_rd_q[sfm_pkg::X_W-1], row_rd_q});
	assign room    = count_q < sfm_pkg::CNT_W'(ROW_MAX);
	assign i_last  = {1'b0, i_q} == (count_q - 1'b1);
	assign e_val   = zero_q ? '0 : rom_rd_q;

	always_comb begin
		if (cmd.div_init) begin
			div_dividend = term_q;
			div_divisor  = sfm_pkg::DIVS_W'({n_q, 8'h00});
			div_steps    = sfm_pkg::STEP_W'(sfm_pkg::Q62_W);
		end else begin
			div_dividend = {exp_rd_q, 16'h0000, (sfm_pkg::Q62_W - sfm_pkg::PROB_STEPS)'(0)};
			div_divisor  = sum_q;
			div_steps    = sfm_pkg::STEP_W'(sfm_pkg::PROB_STEPS);
		end
	end

	sfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quotient (quo)
	);

	sfm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.rom_wr && !(k_q == sfm_pkg::ROM_AW'(sfm_pkg::EXP_LIMIT))),
		.a       (acc_q),
		.b       (base_q[sfm_pkg::BASE_W-1:0]),
		.busy    (mul_busy),
		.product (prod)
	);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.rom_wr) begin
			rom_mem[k_q] <= rounded[62:46];
		end
		if (cmd.exp_rom) begin
			rom_rd_q <= rom_mem[diff[sfm_pkg::ROM_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take && room) begin
			row_mem[count_q[sfm_pkg::IDX_W-1:0]] <= x_value;
		end
		if (cmd.exp_rd) begin
			row_rd_q <= row_mem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_acc) begin
			exp_mem[i_q] <= e_val;
		end
		if (cmd.div_rd) begin
			exp_rd_q <= exp_mem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_rom) begin
			zero_q <= diff[sfm_pkg::X_W] || (diff[sfm_pkg::X_W-1:0] > sfm_pkg::X_W'(sfm_pkg::EXP_LIMIT));
		end
	end

	// exp table build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= ONE_Q62;
			base_q <= ONE_Q62;
			n_q    <= sfm_pkg::TERM_N_W'(1);
			acc_q  <= ONE_Q62;
			k_q    <= '0;
		end else begin
			if (cmd.init_upd) begin
				term_q <= quo;
				base_q <= n_q[0] ? base_q - quo : base_q + quo;
				n_q    <= n_q + 1'b1;
			end
			if (cmd.rom_step) begin
				acc_q <= prod;
				k_q   <= k_q + 1'b1;
			end
		end
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= {1'b1, (sfm_pkg::X_W-1)'(0)};
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
		end else begin
			if (cmd.in_take) begin
				if (room) begin
					if ($signed(x_value) > max_q) begin
						max_q <= $signed(x_value);
					end
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.exp_acc) begin
				sum_q <= sum_q + sfm_pkg::SUM_W'(e_val);
				i_q   <= i_last ? '0 : i_q + 1'b1;
			end
			if (cmd.out_load) begin
				i_q <= i_last ? '0 : i_q + 1'b1;
				if (i_last) begin
					max_q   <= {1'b1, (sfm_pkg::X_W-1)'(0)};
					count_q <= '0;
					sum_q   <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			prob_q  <= quo[sfm_pkg::P_W-1:0];
			last_q  <= i_last;
			trunc_q <= ovf_q;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.mul_busy = mul_busy;
	assign sts.n_last   = n_q == sfm_pkg::TERM_N_W'(sfm_pkg::TERMS);
	assign sts.k_last   = k_q == sfm_pkg::ROM_AW'(sfm_pkg::EXP_LIMIT);
	assign sts.i_last   = i_last;
	assign sts.out_free = !m_valid_q || m_ready;

	assign m_valid       = m_valid_q;
	assign probability   = prob_q;
	assign last_of_row   = last_q;
	assign row_truncated = trunc_q;

endmodule

// ===== hdl/softmax_row.sv =====
// softmax_row: softmax over one row of signed q8.8 logits
// input stream: one logit per transaction, tlast marks the end of a row;
// items are taken one per cycle while a row is being collected
// output stream: one unsigned q1.16 probability per stored logit, in arrival
// order, tlast on the final one, tuser set on every result of a row that
// held more than ROW_MAX items (the extra items are dropped)
// after the last input, an exponential pass reads, looks up and accumulates
// each element in turn, then each result comes from the 33-step shared
// bit-serial divider; the next row is accepted once the final result of
// the current row has entered the output register
// after reset the exponential table is built by a serial multiplier and
// divider; no input is accepted while it is built
// a stalled receiver holds the output register; the divider waits for it
module softmax_row #(
	parameter int ROW_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // x_value[15:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // probability[16:0], zero pad
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // row_truncated
);

	sfm_pkg::cmd_t cmd;
	sfm_pkg::sts_t sts;
	logic [sfm_pkg::P_W-1:0] probability;

	sfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfm_dp #(
		.ROW_MAX (ROW_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.x_value       (s_axis_tdata),
		.m_valid       (m_axis_tvalid),
		.m_ready       (m_axis_tready),
		.probability   (probability),
		.last_of_row   (m_axis_tlast),
		.row_truncated (m_axis_tuser)
	);

	assign m_axis_tdata = {7'h00, probability};

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("output overwritten");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |-> !sts.div_busy && !sts.mul_busy) else $error("input during compute");
	a_result_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.out_load)) else $error("spurious result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import sfm_pkg::*;

	localparam int ROW_LEN = 64;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [X_W-1:0] x;
		logic           last;
	} logit_t;

	typedef struct {
		logic [P_W-1:0] prob;
		logic           last;
		logic           trunc;
	} prob_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	logit_t pending_logits[$];
	prob_t  expected_probs[$];

	int unsigned exp_table[0:EXP_LIMIT];
	logic [X_W-1:0] row_vals[0:STORE_DEPTH-1];
	int  row_peak;
	int  row_fill;
	bit  row_over;

	int  cycles = 0;
	int  errors = 0;
	int  logits_sent;
	int  probs_seen;
	int  rows_done = 0;
	int  rows_cut = 0;
	int  hold_left;
	bit  hold_done;

	softmax_row #(.ROW_MAX(ROW_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	function automatic void build_exp_table();
		logic [63:0] term;
		logic [63:0] base;
		logic [63:0] acc;
		term = 64'd1 << 62;
		base = 64'd1 << 62;
		for (int n = 1; n < 12; n++) begin
			term = term / (64'd256 * n);
			if (n % 2) base = base - term;
			else base = base + term;
		end
		acc = 64'd1 << 62;
		for (int k = 0; k <= EXP_LIMIT; k++) begin
			exp_table[k] = 32'((acc + (64'd1 << 45)) >> 46);
			acc = mul_q62(acc, base);
		end
	endfunction

	function automatic void clear_row();
		row_peak = -32768;
		row_fill = 0;
		row_over = 0;
	endfunction

	// collects each logit; softmax of the collected row when the last logit arrives
	function automatic void predict_softmax(logit_t item);
		int unsigned e[0:STORE_DEPTH-1];
		logic [SUM_W-1:0] sum;
		int k;
		prob_t p;
		logic [63:0] q;
		if (row_fill < ROW_LEN) begin
			row_vals[row_fill] = item.x;
			if ($signed(item.x) > row_peak) row_peak = $signed(item.x);
			row_fill++;
		end else begin
			row_over = 1;
		end
		if (!item.last) return;
		sum = '0;
		for (int i = 0; i < row_fill; i++) begin
			k = row_peak - int'($signed(row_vals[i]));
			e[i] = (k < 0 || k > EXP_LIMIT) ? 0 : exp_table[k];
			sum = sum + SUM_W'(e[i]);
		end
		for (int i = 0; i < row_fill; i++) begin
			q = (sum != 0) ? ((64'(e[i]) << 16) / 64'(sum)) : 64'd0;
			p.prob = q[P_W-1:0];
			p.last = (i + 1 == row_fill);
			p.trunc = row_over;
			expected_probs.push_back(p);
		end
		rows_done++;
		if (row_over) rows_cut++;
		clear_row();
	endfunction

	function automatic void queue_row(int len, int spread);
		logit_t it;
		int base;
		base = $urandom_range(65535) - 32768;
		for (int i = 0; i < len; i++) begin
			if (spread == 0) it.x = 16'($urandom);
			else it.x = 16'(base + int'($urandom_range(2 * spread)) - spread);
			it.last = (i == len - 1);
			pending_logits.push_back(it);
		end
	endfunction

	function automatic void queue_fixed(int v, bit last);
		logit_t it;
		it.x = 16'(v);
		it.last = last;
		pending_logits.push_back(it);
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		build_exp_table();
		clear_row();
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		queue_fixed(0, 1);
		queue_fixed(-32768, 0);
		queue_fixed(32767, 1);
		queue_fixed(0, 0);
		queue_fixed(-3072, 0);
		queue_fixed(-3073, 0);
		queue_fixed(-1, 0);
		queue_fixed(1, 1);
		queue_fixed(16'h5555, 0);
		queue_fixed(16'h5555, 0);
		queue_fixed(16'hAAAA, 1);
		queue_row(64, 600);
		queue_row(67, 900);
		while (pending_logits.size() < 162) begin
			case ($urandom_range(9))
				0: queue_row($urandom_range(1, 12), 0);
				1: queue_row($urandom_range(1, 4), 0);
				default: queue_row($urandom_range(1, 12), $urandom_range(20, 3500));
			endcase
		end
		queue_row(66, 300);
		queue_fixed(-32768, 0);
		queue_fixed(-32768, 1);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 0;
			logits_sent <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				predict_softmax('{x: s_axis_tdata, last: s_axis_tlast});
				void'(pending_logits.pop_front());
				logits_sent <= logits_sent + 1;
			end
			if (pending_logits.size() > 0 &&
			    ((logits_sent > 100 && logits_sent < 150) || $urandom_range(99) >= 20)) begin
				s_axis_tvalid <= 1;
				s_axis_tdata <= pending_logits[0].x;
				s_axis_tlast <= pending_logits[0].last;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		prob_t want;
		if (!arst_n) begin
			m_axis_tready <= 0;
			probs_seen <= 0;
			hold_left <= 0;
			hold_done <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				probs_seen <= probs_seen + 1;
				if (expected_probs.size() == 0) begin
					$error("unexpected probability transaction %0h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_probs.pop_front();
					if (m_axis_tdata[P_W-1:0] !== want.prob) begin
						$error("probability: expected %0d, actual %0d",
						       want.prob, m_axis_tdata[P_W-1:0]);
						errors++;
					end
					if (m_axis_tdata[23:P_W] !== '0) begin
						$error("pad: expected 0, actual %0h", m_axis_tdata[23:P_W]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_row: expected %0b, actual %0b",
						       want.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== want.trunc) begin
						$error("row_truncated: expected %0b, actual %0b",
						       want.trunc, m_axis_tuser);
						errors++;
					end
				end
			end
			if (!hold_done && probs_seen >= 30) begin
				hold_done <= 1;
				hold_left <= 2000;
				m_axis_tready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= (probs_seen > 200 && probs_seen < 300) ||
				                 ($urandom_range(99) >= 20);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		#1;
		wait (pending_logits.size() == 0 && !s_axis_tvalid);
		wait (expected_probs.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d logits in %0d rows (%0d truncated), %0d probabilities checked",
		         logits_sent, rows_done, rows_cut, probs_seen);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
